// ----- hw/rtl/band_energy_beat_detector_core_defines.svh -----
// Assertion macros used by the checker file of the beat detector.
`ifndef BAND_ENERGY_BEAT_DETECTOR_CORE_DEFINES_SVH
`define BAND_ENERGY_BEAT_DETECTOR_CORE_DEFINES_SVH

// Generic clocked assertion with an active-low reset.
`define BEBD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same, on the block's own clock and reset.
`define BEBD_ASSERT_CK(lbl, prop, msg) \
  `BEBD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/bebd_pkg.sv -----
// Package: types, constants and helpers of the band energy beat detector.
`default_nettype none
package bebd_pkg;

  localparam int unsigned NumBands = 3;
  localparam int unsigned NumW     = 48;
  localparam int unsigned DenW     = 32;
  localparam int unsigned MulAW    = 48;
  localparam int unsigned MulBW    = 17;
  localparam int unsigned AccW     = 66;

  localparam logic [31:0] Max32       = 32'hFFFF_FFFF;
  localparam logic [47:0] Max48       = 48'hFFFF_FFFF_FFFF;
  localparam logic [16:0] OneQ16      = 17'd65536;
  localparam logic [16:0] RearmThrMul = 17'd67502;
  localparam logic [31:0] RearmLimit  = 32'd72090;
  localparam logic [31:0] VolumeFloor = 32'd13107;
  localparam logic [16:0] HitThrMul   = 17'd55706;
  localparam logic [16:0] HitLimitMul = 17'd45875;
  localparam logic [31:0] OneQ16W     = 32'd65536;

  localparam logic [31:0] DefaultAvg [NumBands] = '{32'd17695, 32'd22479, 32'd19333};

  typedef enum logic [2:0] {
    CFG_LEARN_FRAMES = 3'd0,
    CFG_RISE_COEFF   = 3'd1,
    CFG_FALL_COEFF   = 3'd2,
    CFG_MEDIUM_COEFF = 3'd3,
    CFG_THR_DECAY    = 3'd4,
    CFG_SUM_DECAY    = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [MulAW-1:0] a;
    logic [MulBW-1:0] b;
    logic [31:0]      c;
    logic [MulBW-1:0] d;
  } mac_req_t;

  typedef struct packed {
    logic [NumW-1:0] num;
    logic [DenW-1:0] den;
  } div_req_t;

  function automatic logic [31:0] sat32_50(input logic [49:0] v);
    sat32_50 = (v[49:32] != 18'd0) ? Max32 : v[31:0];
  endfunction

  function automatic logic [47:0] sat48_51(input logic [50:0] v);
    sat48_51 = (v[50:48] != 3'd0) ? Max48 : v[47:0];
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bebd_mac.sv -----
// Bit-serial multiply-add: a*b + c*d, one multiplier bit per cycle, MSB first.
`default_nettype none
module bebd_mac import bebd_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire mac_req_t        req_i,
  output logic                 done_o,
  output logic [AccW-1:0]      res_o
);

  localparam int unsigned CntW = $clog2(MulBW);

  logic             busy_q;
  logic [CntW-1:0]  cnt_q;
  logic [MulAW-1:0] a_q;
  logic [31:0]      c_q;
  logic [MulBW-1:0] b_q, d_q;
  logic [AccW-1:0]  acc_q, acc_d;

  always_comb begin
    acc_d = {acc_q[AccW-2:0], 1'b0}
          + (b_q[MulBW-1] ? {{(AccW-MulAW){1'b0}}, a_q} : '0)
          + (d_q[MulBW-1] ? {{(AccW-32){1'b0}}, c_q} : '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(MulBW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      c_q   <= req_i.c;
      d_q   <= req_i.d;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[MulBW-2:0], 1'b0};
      d_q   <= {d_q[MulBW-2:0], 1'b0};
    end
  end

  assign res_o = acc_q;

endmodule
`default_nettype wire

// ----- hw/rtl/bebd_div.sv -----
// Restoring divider, one quotient bit per cycle, quotient saturated to 32 bits.
`default_nettype none
module bebd_div import bebd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire div_req_t    req_i,
  output logic             done_o,
  output logic [31:0]      quo_o
);

  localparam int unsigned CntW = $clog2(NumW);

  logic            busy_q;
  logic [CntW-1:0] cnt_q;
  logic [NumW-1:0] num_q;
  logic [DenW-1:0] rem_q, den_q;
  logic [DenW:0]   sh, diff;
  logic            ge;
  logic [NumW-1:0] q_full;

  assign sh     = {rem_q, num_q[NumW-1]};
  assign ge     = sh >= {1'b0, den_q};
  assign diff   = sh - {1'b0, den_q};
  assign q_full = {num_q[NumW-2:0], ge};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(NumW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= req_i.num;
      den_q <= req_i.den;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[DenW-1:0] : sh[DenW-1:0];
      num_q <= q_full;
      if (cnt_q == CntW'(NumW - 1)) begin
        // zero divisor and overflow both saturate
        quo_o <= (den_q == '0 || q_full[NumW-1:32] != '0) ? Max32 : q_full[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/band_energy_beat_detector_core.sv -----
// Top level of the band energy beat detector: frame sequencer and state.
//
//  channel  dir  handshake             payload
//  s_axis   in   s_axis_tvalid/tready  tdata: low, mid, high band energy (3 x 32)
//  m_axis   out  m_axis_tvalid/tready  tdata: is_beat, volume_ratio, beat_threshold
//  cfg      in   cfg_valid/cfg_ready   cfg_index (3), cfg_data (17)
//
// One frame, from one accepted request to the next, runs these steps: per band a
// 17-step MAC for the sum, up to three 48-step divisions and two 17-step blends,
// then the divide by three, the threshold blend and up to two more MACs. The serial
// divider and serial MAC carry out all of this arithmetic.
// After reset all state holds its initial values; no clearing pass is needed.
// A new frame is accepted while the previous result waits; the last step stalls
// until the output register is free. cfg writes are always taken.
`default_nettype none
module band_energy_beat_detector_core import bebd_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [95:0] s_axis_tdata_i,  // low[31:0], mid[63:32], high[95:64]
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [71:0]      m_axis_tdata_o,  // is_beat[0], volume[32:1], thr[64:33], 0
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM, ST_LRN, ST_NORM, ST_FAST, ST_MED, ST_RAT,
    ST_VOL, ST_THR, ST_HIT1, ST_HIT2, ST_REARM, ST_OUT
  } state_e;

  state_e      state_q;
  logic        go_q;
  logic [1:0]  bi_q;

  logic [15:0] learn_q, rise_q, fall_q, medc_q, tdec_q;
  logic [16:0] sdec_q;

  logic [31:0] en_q     [NumBands];
  logic [47:0] sums_q   [NumBands];
  logic [31:0] learned_q[NumBands];
  logic [31:0] fast_q   [NumBands];
  logic [31:0] med_q    [NumBands];
  logic [31:0] timer_q, thr_q, limit_q, last_q, norm_q, vol_q;
  logic        fallen_q, beat_q;
  logic [33:0] racc_q;

  logic        out_valid_q;
  logic [71:0] out_data_q;

  mac_req_t    mac_req;
  div_req_t    div_req;
  logic        mac_start, div_start, mac_done, div_done;
  logic [AccW-1:0] mac_res;
  logic [31:0] div_quo;

  logic [16:0] sd, kfast;
  logic        lrn_use;
  logic [31:0] blend_res, mulq_res;
  logic [50:0] sum_new;

  assign sd        = (sdec_q > OneQ16) ? OneQ16 : sdec_q;
  assign lrn_use   = timer_q > {16'd0, learn_q};
  assign kfast     = (norm_q > fast_q[bi_q]) ? {1'b0, rise_q} : {1'b0, fall_q};
  assign blend_res = mac_res[47:16];
  assign mulq_res  = sat32_50(mac_res[65:16]);
  assign sum_new   = {1'b0, mac_res[65:16]} + {19'd0, en_q[bi_q]};

  always_comb begin
    mac_start = 1'b0;
    div_start = 1'b0;
    mac_req   = '0;
    div_req   = '0;
    unique case (state_q)
      ST_SUM: begin
        mac_start = go_q;
        mac_req.a = sums_q[bi_q];
        mac_req.b = sd;
      end
      ST_LRN: begin
        div_start   = go_q & lrn_use;
        div_req.num = sums_q[bi_q];
        div_req.den = timer_q - {16'd0, learn_q};
      end
      ST_NORM: begin
        div_start   = go_q;
        div_req.num = {en_q[bi_q], 16'd0};
        div_req.den = learned_q[bi_q];
      end
      ST_FAST: begin
        mac_start = go_q;
        mac_req.a = {16'd0, fast_q[bi_q]};
        mac_req.b = kfast;
        mac_req.c = norm_q;
        mac_req.d = OneQ16 - kfast;
      end
      ST_MED: begin
        mac_start = go_q;
        mac_req.a = {16'd0, med_q[bi_q]};
        mac_req.b = {1'b0, medc_q};
        mac_req.c = norm_q;
        mac_req.d = OneQ16 - {1'b0, medc_q};
      end
      ST_RAT: begin
        div_start   = go_q;
        div_req.num = {fast_q[bi_q], 16'd0};
        div_req.den = med_q[bi_q];
      end
      ST_VOL: begin
        div_start   = go_q;
        div_req.num = {14'd0, racc_q};
        div_req.den = 32'(NumBands);
      end
      ST_THR: begin
        mac_start = go_q;
        mac_req.a = {16'd0, thr_q};
        mac_req.b = {1'b0, tdec_q};
        mac_req.c = limit_q;
        mac_req.d = OneQ16 - {1'b0, tdec_q};
      end
      ST_HIT1: begin
        mac_start = go_q;
        mac_req.a = {16'd0, vol_q};
        mac_req.b = HitThrMul;
      end
      ST_HIT2: begin
        mac_start = go_q;
        mac_req.a = {16'd0, vol_q};
        mac_req.b = HitLimitMul;
      end
      ST_REARM: begin
        mac_start = go_q;
        mac_req.a = {16'd0, last_q};
        mac_req.b = RearmThrMul;
      end
      default: ;
    endcase
  end

  bebd_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mac_start),
    .req_i   (mac_req),
    .done_o  (mac_done),
    .res_o   (mac_res)
  );

  bebd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .req_i   (div_req),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      go_q        <= 1'b0;
      bi_q        <= '0;
      learn_q     <= 16'd300;
      rise_q      <= 16'd2621;
      fall_q      <= 16'd16384;
      medc_q      <= 16'd61034;
      tdec_q      <= 16'd58112;
      sdec_q      <= OneQ16;
      for (int b = 0; b < NumBands; b++) begin
        sums_q[b]    <= '0;
        learned_q[b] <= '0;
        fast_q[b]    <= '0;
        med_q[b]     <= '0;
        en_q[b]      <= '0;
      end
      timer_q     <= 32'd1;
      thr_q       <= OneQ16W;
      limit_q     <= OneQ16W;
      fallen_q    <= 1'b1;
      last_q      <= '0;
      beat_q      <= 1'b0;
      racc_q      <= '0;
      norm_q      <= '0;
      vol_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_LEARN_FRAMES: learn_q <= cfg_data_i[15:0];
          CFG_RISE_COEFF:   rise_q  <= cfg_data_i[15:0];
          CFG_FALL_COEFF:   fall_q  <= cfg_data_i[15:0];
          CFG_MEDIUM_COEFF: medc_q  <= cfg_data_i[15:0];
          CFG_THR_DECAY:    tdec_q  <= cfg_data_i[15:0];
          CFG_SUM_DECAY:    sdec_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_valid_q && m_axis_tready_i) out_valid_q <= 1'b0;
      if (go_q) go_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid_i) begin
            en_q[0] <= s_axis_tdata_i[31:0];
            en_q[1] <= s_axis_tdata_i[63:32];
            en_q[2] <= s_axis_tdata_i[95:64];
            bi_q    <= '0;
            racc_q  <= '0;
            beat_q  <= 1'b0;
            state_q <= ST_SUM;
            go_q    <= 1'b1;
          end
        end
        ST_SUM: begin
          if (mac_done) begin
            sums_q[bi_q] <= sat48_51(sum_new);
            state_q      <= ST_LRN;
            go_q         <= 1'b1;
          end
        end
        ST_LRN: begin
          if (!lrn_use) begin
            learned_q[bi_q] <= DefaultAvg[bi_q];
            state_q         <= ST_NORM;
            go_q            <= 1'b1;
          end else if (div_done) begin
            learned_q[bi_q] <= div_quo;
            state_q         <= ST_NORM;
            go_q            <= 1'b1;
          end
        end
        ST_NORM: begin
          if (div_done) begin
            norm_q  <= div_quo;
            state_q <= ST_FAST;
            go_q    <= 1'b1;
          end
        end
        ST_FAST: begin
          if (mac_done) begin
            fast_q[bi_q] <= blend_res;
            state_q      <= ST_MED;
            go_q         <= 1'b1;
          end
        end
        ST_MED: begin
          if (mac_done) begin
            med_q[bi_q] <= blend_res;
            state_q     <= ST_RAT;
            go_q        <= 1'b1;
          end
        end
        ST_RAT: begin
          if (div_done) begin
            racc_q <= racc_q + {2'd0, div_quo};
            go_q   <= 1'b1;
            if (bi_q == 2'(NumBands - 1)) begin
              bi_q    <= '0;
              state_q <= ST_VOL;
              // timer moves only after every band has used it
              if (timer_q != Max32) timer_q <= timer_q + 32'd1;
            end else begin
              bi_q    <= bi_q + 2'd1;
              state_q <= ST_SUM;
            end
          end
        end
        ST_VOL: begin
          if (div_done) begin
            vol_q   <= div_quo;
            state_q <= ST_THR;
            go_q    <= 1'b1;
          end
        end
        ST_THR: begin
          if (mac_done) begin
            thr_q <= blend_res;
            if (!fallen_q) begin
              if (vol_q < blend_res) begin
                fallen_q <= 1'b1;
                limit_q  <= RearmLimit;
                state_q  <= ST_REARM;
                go_q     <= 1'b1;
              end else begin
                state_q <= ST_OUT;
              end
            end else if (vol_q > blend_res && vol_q > VolumeFloor) begin
              beat_q   <= 1'b1;
              last_q   <= vol_q;
              fallen_q <= 1'b0;
              state_q  <= ST_HIT1;
              go_q     <= 1'b1;
            end else begin
              state_q <= ST_OUT;
            end
          end
        end
        ST_HIT1: begin
          if (mac_done) begin
            thr_q   <= (mulq_res > OneQ16W) ? mulq_res : OneQ16W;
            state_q <= ST_HIT2;
            go_q    <= 1'b1;
          end
        end
        ST_HIT2: begin
          if (mac_done) begin
            limit_q <= (mulq_res > OneQ16W) ? mulq_res : OneQ16W;
            state_q <= ST_OUT;
          end
        end
        ST_REARM: begin
          if (mac_done) begin
            thr_q   <= mulq_res;
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready_i) begin
            out_data_q  <= {7'd0, thr_q, vol_q, beat_q};
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign cfg_ready_o     = 1'b1;

endmodule
`default_nettype wire

// ----- hw/rtl/bebd_checker.sv -----
// Port-level checker of the beat detector and its bind to the top level.
`default_nettype none
`include "band_energy_beat_detector_core_defines.svh"
module bebd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic [95:0] s_axis_tdata_i,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [71:0] m_axis_tdata_o,
  input wire logic        cfg_valid_i,
  input wire logic        cfg_ready_o,
  input wire logic [2:0]  cfg_index_i,
  input wire logic [16:0] cfg_data_i
);

  // a stalled result stays offered
  `BEBD_ASSERT_CK(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o, "result dropped")

  // a frame keeps the block busy for at least the next cycle
  `BEBD_ASSERT_CK(a_busy_after_req, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "ready too early")

  // a beat needs a volume above the floor
  `BEBD_ASSERT_CK(a_beat_floor, m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[32:1] > 32'd13107, "beat below floor")

  // the threshold after a beat is at least one
  `BEBD_ASSERT_CK(a_beat_thr, m_axis_tvalid_o && m_axis_tdata_o[0] |-> m_axis_tdata_o[64:33] >= 32'd65536, "beat threshold below one")

endmodule

bind band_energy_beat_detector_core bebd_checker u_bebd_checker (.*);
`default_nettype wire

// ----- dv/testbench.sv -----
// Testbench for the band energy beat detector core: directed and random frames vs a predictor.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import bebd_pkg::*;

  // same bit order as m_axis_tdata_o: is_beat lowest
  typedef struct packed {
    logic [31:0] threshold;
    logic [31:0] volume;
    logic        is_beat;
  } beat_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [95:0] s_axis_tdata_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [71:0] m_axis_tdata_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [16:0] cfg_data_i = '0;

  band_energy_beat_detector_core dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state and register mirror
  logic [47:0] band_sum [NumBands];
  logic [31:0] learned_avg [NumBands];
  logic [31:0] fast_avg [NumBands];
  logic [31:0] medium_avg [NumBands];
  logic [31:0] frame_count, thr_level, limit_lvl, last_hit;
  logic        fallen;
  logic [15:0] learn_frames_r, rise_r, fall_r, medium_r, thr_decay_r;
  logic [16:0] sum_decay_r;

  beat_result_t pending_results [$];
  int mismatches = 0;
  bit calm = 1'b0;       // no random idling on either side
  int stall_request = 0; // bumped to ask the receiver for a long hold-off

  function automatic logic [31:0] sat_div(logic [63:0] num, logic [63:0] den);
    logic [63:0] q;
    if (den == 0) return Max32;
    q = num / den;
    return (q > 64'hFFFF_FFFF) ? Max32 : q[31:0];
  endfunction

  function automatic logic [31:0] mix_q16(logic [31:0] old, logic [31:0] val, logic [16:0] k);
    logic [63:0] t;
    t = 64'(old) * 64'(k) + 64'(val) * (64'd65536 - 64'(k));
    return t[47:16];
  endfunction

  function automatic logic [31:0] scale_q16(logic [31:0] v, logic [16:0] m);
    logic [63:0] p;
    p = (64'(v) * 64'(m)) >> 16;
    return (p > 64'hFFFF_FFFF) ? Max32 : p[31:0];
  endfunction

  task automatic predict_frame(input logic [31:0] e [NumBands]);
    logic [63:0] sd, s, ns, acc;
    logic [31:0] norm, vol, t, l;
    logic [16:0] k;
    beat_result_t r;
    sd = (sum_decay_r > OneQ16) ? 64'd65536 : 64'(sum_decay_r);
    acc = 0;
    r = '0;
    for (int b = 0; b < NumBands; b++) begin
      s = 64'(band_sum[b]);
      ns = (s >> 16) * sd + (((s & 64'hFFFF) * sd) >> 16) + 64'(e[b]);
      band_sum[b] = (ns > 64'(Max48)) ? Max48 : ns[47:0];
    end
    for (int b = 0; b < NumBands; b++)
      learned_avg[b] = (frame_count > 32'(learn_frames_r)) ?
          sat_div(64'(band_sum[b]), 64'(frame_count - 32'(learn_frames_r))) : DefaultAvg[b];
    if (frame_count != Max32) frame_count++;
    for (int b = 0; b < NumBands; b++) begin
      norm = sat_div(64'(e[b]) << 16, 64'(learned_avg[b]));
      k = (norm > fast_avg[b]) ? 17'(rise_r) : 17'(fall_r);
      fast_avg[b] = mix_q16(fast_avg[b], norm, k);
      medium_avg[b] = mix_q16(medium_avg[b], norm, 17'(medium_r));
    end
    for (int b = 0; b < NumBands; b++)
      acc += 64'(sat_div(64'(fast_avg[b]) << 16, 64'(medium_avg[b])));
    vol = 32'(acc / 3);
    thr_level = mix_q16(thr_level, limit_lvl, 17'(thr_decay_r));
    if (!fallen) begin
      if (vol < thr_level) begin
        fallen = 1'b1;
        thr_level = scale_q16(last_hit, RearmThrMul);
        limit_lvl = RearmLimit;
      end
    end else if (vol > thr_level && vol > VolumeFloor) begin
      t = scale_q16(vol, HitThrMul);
      l = scale_q16(vol, HitLimitMul);
      r.is_beat = 1'b1;
      last_hit = vol;
      fallen = 1'b0;
      thr_level = (t > OneQ16W) ? t : OneQ16W;
      limit_lvl = (l > OneQ16W) ? l : OneQ16W;
    end
    r.volume = vol;
    r.threshold = thr_level;
    pending_results.push_back(r);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LEARN_FRAMES: learn_frames_r = data[15:0];
      CFG_RISE_COEFF:   rise_r = data[15:0];
      CFG_FALL_COEFF:   fall_r = data[15:0];
      CFG_MEDIUM_COEFF: medium_r = data[15:0];
      CFG_THR_DECAY:    thr_decay_r = data[15:0];
      CFG_SUM_DECAY:    sum_decay_r = data;
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // leaves tvalid high after the request is taken; stop_frames lowers it
  task automatic send_frame(input logic [31:0] lo, input logic [31:0] mi, input logic [31:0] hi);
    logic [31:0] e [NumBands];
    if (!calm && $urandom_range(99) < 7) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {hi, mi, lo};
    do @(posedge clk_i); while (!s_axis_tready_o);
    e[0] = lo;
    e[1] = mi;
    e[2] = hi;
    predict_frame(e);
  endtask

  task automatic stop_frames();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    stop_frames();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_energy(logic [31:0] base, bit spike);
    case ($urandom_range(19))
      0: return $urandom();
      1: return '0;
      2: return Max32;
      default: return spike ? base * $urandom_range(3, 8) : base + $urandom_range(0, base >> 2);
    endcase
  endfunction

  // receiver: random idling, calm stretches and long hold-offs on request
  int stall_seen = 0;
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_request != stall_seen) begin
      stall_seen = stall_request;
      stall_left = 4000;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= calm ? 1'b1 : ($urandom_range(99) >= 7);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    beat_result_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[64:0];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got.is_beat !== want.is_beat || got.volume !== want.volume ||
            got.threshold !== want.threshold || m_axis_tdata_o[71:65] !== '0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: beat %b/%b vol %h/%h thr %h/%h (exp/act)",
                     want.is_beat, got.is_beat, want.volume, got.volume,
                     want.threshold, got.threshold);
        end
      end
    end
  end

  task automatic test_defaults_and_zero();
    // zero input: medium averages stay zero, ratios hit the zero-divisor case
    repeat (3) send_frame('0, '0, '0);
    send_frame(Max32, Max32, Max32);
    send_frame(32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
    repeat (2) send_frame(32'h0000_4000, 32'h0000_5000, 32'h0000_4800);
    send_frame(32'h0010_0000, 32'h0012_0000, 32'h0011_0000); // loud hit
    send_frame(32'h0000_4000, 32'h0000_5000, 32'h0000_4800);
    wait_idle();
  endtask

  task automatic test_special_cases();
    // out-of-range indexes ignored; bit 16 masked on 16-bit registers
    write_reg(3'd6, 17'h1FFFF);
    write_reg(3'd7, 17'h0);
    write_reg(CFG_LEARN_FRAMES, 17'h1_0000); // learned average from sums, now zero
    write_reg(CFG_SUM_DECAY, 17'h1FFFF);     // above one acts as one
    write_reg(CFG_RISE_COEFF, 17'h1_FFFF);
    write_reg(CFG_FALL_COEFF, 17'h0);
    write_reg(CFG_MEDIUM_COEFF, 17'h0);
    write_reg(CFG_THR_DECAY, 17'h1_0000);
    send_frame(Max32, 32'h1, 32'h0);
    send_frame(32'h1, Max32, 32'h8000_0000);
    send_frame(32'h0, 32'h0, Max32);
    send_frame(32'h0000_0100, 32'h7FFF_FFFF, 32'h0000_0001);
    wait_idle();
    write_reg(CFG_SUM_DECAY, 17'd0);
    write_reg(CFG_MEDIUM_COEFF, 17'd65535);
    write_reg(CFG_THR_DECAY, 17'd65535);
    send_frame(32'h0000_1000, 32'h0000_1000, 32'h0000_1000);
    send_frame(Max32, Max32, Max32);
    send_frame(32'h0000_0001, 32'h0000_0001, 32'h0000_0001);
    wait_idle();
  endtask

  task automatic random_frames(input int count);
    logic [31:0] base [NumBands];
    bit spike;
    for (int b = 0; b < NumBands; b++) base[b] = $urandom_range(32'h800, 32'h4_0000);
    for (int i = 0; i < count; i++) begin
      spike = ($urandom_range(7) == 0);
      if ($urandom_range(63) == 0)
        for (int b = 0; b < NumBands; b++) base[b] = $urandom_range(32'h10, 32'h10_0000);
      send_frame(pick_energy(base[0], spike), pick_energy(base[1], spike),
                 pick_energy(base[2], spike));
    end
  endtask

  task automatic test_config_sweep();
    logic [16:0] extreme [4] = '{17'd0, 17'd65535, 17'd1, 17'd32768};
    for (int p = 0; p < 5; p++) begin
      write_reg(CFG_LEARN_FRAMES, (p == 4) ? 17'd65535 : 17'($urandom_range(0, 40)));
      write_reg(CFG_RISE_COEFF, (p < 4) ? extreme[p] : 17'($urandom_range(65535)));
      write_reg(CFG_FALL_COEFF, (p < 4) ? extreme[3 - p] : 17'($urandom_range(65535)));
      write_reg(CFG_MEDIUM_COEFF, 17'($urandom_range(40000, 65535)));
      write_reg(CFG_THR_DECAY, (p == 1) ? 17'd0 : 17'($urandom_range(30000, 65535)));
      write_reg(CFG_SUM_DECAY, (p == 2) ? 17'd0 : 17'($urandom_range(60000, 70000)));
      calm = (p == 3);
      random_frames(330);
      wait_idle();
    end
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    stall_request++;
    random_frames(12); // sender keeps offering while the output is held
    wait_idle();
    random_frames(20);
    wait_idle();       // pause until every expected result is back
    random_frames(150);
    wait_idle();
  endtask

  initial begin
    learn_frames_r = 16'd300;
    rise_r = 16'd2621;
    fall_r = 16'd16384;
    medium_r = 16'd61034;
    thr_decay_r = 16'd58112;
    sum_decay_r = 17'd65536;
    for (int b = 0; b < NumBands; b++) begin
      band_sum[b] = '0;
      learned_avg[b] = '0;
      fast_avg[b] = '0;
      medium_avg[b] = '0;
    end
    frame_count = 32'd1;
    thr_level = OneQ16W;
    limit_lvl = OneQ16W;
    fallen = 1'b1;
    last_hit = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_defaults_and_zero();
    test_special_cases();
    test_config_sweep();
    test_backpressure();
    repeat (1000) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule
`default_nettype wire

// ----- band_energy_beat_detector_core.f -----
+incdir+hw/rtl
hw/rtl/bebd_pkg.sv
hw/rtl/bebd_mac.sv
hw/rtl/bebd_div.sv
hw/rtl/band_energy_beat_detector_core.sv
hw/rtl/bebd_checker.sv
dv/testbench.sv
